### design/source_text_tokenizer_assert.svh
// Assertion macros for the source text tokenizer
`ifndef SOURCE_TEXT_TOKENIZER_ASSERT_SVH
`define SOURCE_TEXT_TOKENIZER_ASSERT_SVH
// implication checked on every clock edge outside reset
`define STT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// implication whose consequent is checked in the cycle after the antecedent
`define STT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`endif

### design/stt_pkg.sv
// Package: token kinds, scan modes, keyword table and shared types
package stt_pkg;
  localparam int NKW = 24;
  localparam logic [19:0] LINE_MAX = 20'hFFFFF;
  localparam logic [15:0] COL_MAX = 16'hFFFF;
  localparam logic [62:0] VAL_MAX = {63{1'b1}};

  localparam logic [5:0] K_EOF = 6'd0;
  localparam logic [5:0] K_INT = 6'd1;
  localparam logic [5:0] K_FLOAT = 6'd2;
  localparam logic [5:0] K_STRING = 6'd3;
  localparam logic [5:0] K_IDENT = 6'd4;
  localparam logic [5:0] K_KW0 = 6'd5;
  localparam logic [5:0] K_OP0 = 6'd29;
  localparam logic [5:0] K_SLASH = 6'd42;
  localparam logic [5:0] K_NE = 6'd44;
  localparam logic [5:0] K_BANG = 6'd45;
  localparam logic [5:0] K_EQEQ = 6'd46;
  localparam logic [5:0] K_EQ = 6'd47;
  localparam logic [5:0] K_LE = 6'd48;
  localparam logic [5:0] K_LT = 6'd49;
  localparam logic [5:0] K_GE = 6'd50;
  localparam logic [5:0] K_GT = 6'd51;
  localparam logic [5:0] K_ANDAND = 6'd52;
  localparam logic [5:0] K_OROR = 6'd53;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_UNEXP = 2'd1;
  localparam logic [1:0] ST_UNTERM = 2'd2;

  typedef enum logic [3:0] {
    M_IDLE, M_IDENT, M_INT, M_FRAC, M_STR, M_ESC, M_SLASH, M_COMMENT,
    M_BANG, M_EQ, M_LT, M_GT, M_AMP, M_BAR, M_HALT
  } mode_t;

  typedef struct packed {
    logic [5:0]  kind;
    logic [19:0] line;
    logic [15:0] column;
    logic [31:0] offset;
    logic [15:0] length;
    logic [62:0] value;
    logic [1:0]  status;
  } tok_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] text_byte;
    logic       end_of_input;
  } item_t;

  typedef struct packed {
    logic [1:0] count;
    tok_t       tok0;
    tok_t       tok1;
  } res_t;

  function automatic logic [3:0] kw_len(input logic [4:0] k);
    case (k)
      5'd0, 5'd8, 5'd23: kw_len = 4'd7;
      5'd1: kw_len = 4'd9;
      5'd2: kw_len = 4'd10;
      5'd3, 5'd6, 5'd15, 5'd17, 5'd19: kw_len = 4'd5;
      5'd4, 5'd5, 5'd14, 5'd16, 5'd20, 5'd22: kw_len = 4'd4;
      5'd7, 5'd11, 5'd13: kw_len = 4'd2;
      5'd9, 5'd10, 5'd18: kw_len = 4'd3;
      5'd12, 5'd21: kw_len = 4'd6;
      default: kw_len = 4'd0;
    endcase
  endfunction

  function automatic logic [7:0] kw_char(input logic [4:0] k, input logic [3:0] i);
    logic [79:0] s;
    case (k)
      5'd0: s = "process";
      5'd1: s = "coroutine";
      5'd2: s = "supervisor";
      5'd3: s = "spawn";
      5'd4: s = "send";
      5'd5: s = "recv";
      5'd6: s = "yield";
      5'd7: s = "on";
      5'd8: s = "receive";
      5'd9: s = "let";
      5'd10: s = "mut";
      5'd11: s = "fn";
      5'd12: s = "return";
      5'd13: s = "if";
      5'd14: s = "else";
      5'd15: s = "while";
      5'd16: s = "true";
      5'd17: s = "false";
      5'd18: s = "int";
      5'd19: s = "float";
      5'd20: s = "bool";
      5'd21: s = "string";
      5'd22: s = "void";
      5'd23: s = "restart";
      default: s = '0;
    endcase
    // left aligned characters; string literal is right aligned
    kw_char = 8'h00;
    for (int j = 0; j < 10; j++) begin
      if (j == 32'(kw_len(k)) - 1 - 32'(i) && i < kw_len(k)) kw_char = s[j*8 +: 8];
    end
  endfunction

  function automatic logic [5:0] single_op(input logic [7:0] c);
    case (c)
      "(": single_op = K_OP0;
      ")": single_op = K_OP0 + 6'd1;
      "{": single_op = K_OP0 + 6'd2;
      "}": single_op = K_OP0 + 6'd3;
      "[": single_op = K_OP0 + 6'd4;
      "]": single_op = K_OP0 + 6'd5;
      ",": single_op = K_OP0 + 6'd6;
      ":": single_op = K_OP0 + 6'd7;
      ";": single_op = K_OP0 + 6'd8;
      ".": single_op = K_OP0 + 6'd9;
      "+": single_op = K_OP0 + 6'd10;
      "-": single_op = K_OP0 + 6'd11;
      "*": single_op = K_OP0 + 6'd12;
      "/": single_op = K_OP0 + 6'd13;
      "%": single_op = K_OP0 + 6'd14;
      default: single_op = K_EOF;
    endcase
  endfunction
endpackage

### design/stt_scan.sv
// Scanner core: registered state, per-byte next-state and token formation
module stt_scan (
  input  logic           clk,
  input  logic           rst_n,
  input  stt_pkg::item_t item,
  output stt_pkg::res_t  res
);
  import stt_pkg::*;

  mode_t       mode_r, mode_nxt;
  logic [19:0] cline_r, cline_nxt, tline_r, tline_nxt;
  logic [15:0] ccol_r, ccol_nxt, tcol_r, tcol_nxt;
  logic [31:0] coff_r, coff_nxt, toff_r, toff_nxt;
  logic [15:0] tlen_r, tlen_nxt;
  logic [62:0] acc_r, acc_nxt;
  logic [NKW-1:0] cand_r, cand_nxt;

  logic [7:0] c;
  logic is_dig, is_ids, rescan;
  logic [5:0] ident_k;
  logic [3:0] d;
  logic [66:0] prod;
  tok_t t_pend, t_new;
  logic put_pend, put_new;

  assign c = item.text_byte;
  assign is_dig = (c >= "0") && (c <= "9");
  assign is_ids = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
  assign d = c[3:0];
  assign prod = {acc_r, 3'b000} + {2'b00, acc_r, 1'b0} + {63'd0, d};

  always_comb begin
    ident_k = K_IDENT;
    for (int k = NKW - 1; k >= 0; k--) begin
      if (cand_r[k] && tlen_r == {12'd0, kw_len(5'(k))}) ident_k = K_KW0 + 6'(k);
    end
  end

  function automatic logic [NKW-1:0] kw_filter(input logic [NKW-1:0] m,
                                              input logic [15:0] idx,
                                              input logic [7:0] ch);
    logic [NKW-1:0] r;
    r = m;
    for (int k = 0; k < NKW; k++) begin
      if (idx >= {12'd0, kw_len(5'(k))} || kw_char(5'(k), idx[3:0]) != ch) r[k] = 1'b0;
    end
    return r;
  endfunction

  always_comb begin
    logic [15:0] len_inc;
    logic [31:0] off_inc;
    mode_t m;
    mode_nxt = mode_r;
    cline_nxt = cline_r; ccol_nxt = ccol_r; coff_nxt = coff_r;
    tline_nxt = tline_r; tcol_nxt = tcol_r; toff_nxt = toff_r;
    tlen_nxt = tlen_r; acc_nxt = acc_r; cand_nxt = cand_r;
    put_pend = 1'b0; put_new = 1'b0; rescan = 1'b0;
    t_pend = '0; t_new = '0;
    len_inc = (tlen_r == COL_MAX) ? tlen_r : tlen_r + 16'd1;
    off_inc = coff_r + 32'd1;
    t_pend.line = tline_r; t_pend.column = tcol_r; t_pend.offset = toff_r;
    t_pend.length = tlen_r;
    m = mode_r;
    if (item.end_of_input) begin
      case (mode_r)
        M_IDENT: begin put_pend = 1'b1; t_pend.kind = ident_k; end
        M_INT: begin put_pend = 1'b1; t_pend.kind = K_INT; t_pend.value = acc_r; end
        M_FRAC: begin put_pend = 1'b1; t_pend.kind = K_FLOAT; end
        M_SLASH: begin put_pend = 1'b1; t_pend.kind = K_SLASH; end
        M_BANG: begin put_pend = 1'b1; t_pend.kind = K_BANG; end
        M_EQ: begin put_pend = 1'b1; t_pend.kind = K_EQ; end
        M_LT: begin put_pend = 1'b1; t_pend.kind = K_LT; end
        M_GT: begin put_pend = 1'b1; t_pend.kind = K_GT; end
        M_AMP, M_BAR: begin
          put_pend = 1'b1; t_pend.length = 16'd1; t_pend.status = ST_UNEXP;
        end
        M_STR, M_ESC: begin put_pend = 1'b1; t_pend.status = ST_UNTERM; end
        default: ;
      endcase
      put_new = 1'b1;
      t_new.line = cline_r; t_new.column = ccol_r; t_new.offset = coff_r;
      mode_nxt = M_IDLE;
      cline_nxt = 20'd1; ccol_nxt = 16'd1; coff_nxt = '0;
      tline_nxt = 20'd1; tcol_nxt = 16'd1; toff_nxt = '0; tlen_nxt = '0;
      acc_nxt = '0; cand_nxt = '1;
    end else begin
      case (mode_r)
        M_IDENT:
          if (is_ids || is_dig) begin
            cand_nxt = kw_filter(cand_r, tlen_r, c);
            tlen_nxt = len_inc;
          end else begin
            put_pend = 1'b1; t_pend.kind = ident_k; rescan = 1'b1;
          end
        M_INT:
          if (is_dig) begin
            acc_nxt = (prod[66:63] != 4'd0) ? VAL_MAX : prod[62:0];
            tlen_nxt = len_inc;
          end else if (c == ".") begin
            mode_nxt = M_FRAC; tlen_nxt = len_inc;
          end else begin
            put_pend = 1'b1; t_pend.kind = K_INT; t_pend.value = acc_r; rescan = 1'b1;
          end
        M_FRAC:
          if (is_dig) tlen_nxt = len_inc;
          else begin put_pend = 1'b1; t_pend.kind = K_FLOAT; rescan = 1'b1; end
        M_STR:
          if (c == "\"") begin
            put_pend = 1'b1; t_pend.kind = K_STRING; mode_nxt = M_IDLE;
          end else begin
            tlen_nxt = len_inc;
            if (c == "\\") mode_nxt = M_ESC;
          end
        M_ESC: begin tlen_nxt = len_inc; mode_nxt = M_STR; end
        M_SLASH:
          if (c == "/") mode_nxt = M_COMMENT;
          else begin put_pend = 1'b1; t_pend.kind = K_SLASH; rescan = 1'b1; end
        M_COMMENT: if (c == 8'h0A) rescan = 1'b1;
        M_BANG, M_EQ, M_LT, M_GT: begin
          t_pend.kind = (m == M_BANG) ? K_BANG : (m == M_EQ) ? K_EQ :
                        (m == M_LT) ? K_LT : K_GT;
          put_pend = 1'b1;
          if (c == "=") begin
            t_pend.kind = t_pend.kind - 6'd1; t_pend.length = 16'd2; mode_nxt = M_IDLE;
          end else rescan = 1'b1;
        end
        M_AMP, M_BAR: begin
          put_pend = 1'b1; mode_nxt = M_IDLE;
          if (c == ((m == M_AMP) ? 8'h26 : 8'h7C)) begin
            t_pend.kind = (m == M_AMP) ? K_ANDAND : K_OROR; t_pend.length = 16'd2;
          end else begin
            t_pend.length = 16'd1; t_pend.status = ST_UNEXP; mode_nxt = M_HALT;
          end
        end
        default: ;
      endcase
      // position advance for bytes consumed in a busy mode
      if (mode_r != M_IDLE && mode_r != M_HALT && !rescan &&
          !(mode_r inside {M_AMP, M_BAR} && t_pend.status == ST_UNEXP)) begin
        coff_nxt = off_inc;
        if (mode_r == M_STR && c == 8'h0A) begin
          if (cline_r != LINE_MAX) cline_nxt = cline_r + 20'd1;
          ccol_nxt = 16'd1;
        end else if (ccol_r != COL_MAX) ccol_nxt = ccol_r + 16'd1;
      end
      if (mode_r == M_IDLE || rescan) begin
        mode_nxt = M_IDLE;
        coff_nxt = off_inc;
        if (ccol_r != COL_MAX) ccol_nxt = ccol_r + 16'd1;
        if (c == 8'h20 || c == 8'h09 || c == 8'h0D) begin
        end else if (c == 8'h0A) begin
          if (cline_r != LINE_MAX) cline_nxt = cline_r + 20'd1;
          ccol_nxt = 16'd1;
        end else begin
          tline_nxt = cline_r; tcol_nxt = ccol_r; toff_nxt = coff_r; tlen_nxt = 16'd1;
          if (is_dig) begin
            mode_nxt = M_INT; acc_nxt = {59'd0, d};
          end else if (is_ids) begin
            mode_nxt = M_IDENT; cand_nxt = kw_filter('1, 16'd0, c);
          end else if (c == "\"") begin
            mode_nxt = M_STR; toff_nxt = off_inc; tlen_nxt = '0;
          end else if (c == "/") mode_nxt = M_SLASH;
          else if (c == "!") mode_nxt = M_BANG;
          else if (c == "=") mode_nxt = M_EQ;
          else if (c == "<") mode_nxt = M_LT;
          else if (c == ">") mode_nxt = M_GT;
          else if (c == "&") mode_nxt = M_AMP;
          else if (c == "|") mode_nxt = M_BAR;
          else begin
            put_new = 1'b1;
            t_new.line = cline_r; t_new.column = ccol_r; t_new.offset = coff_r;
            t_new.length = 16'd1;
            t_new.kind = single_op(c);
            if (single_op(c) == K_EOF) begin
              t_new.status = ST_UNEXP; mode_nxt = M_HALT;
              coff_nxt = coff_r; ccol_nxt = ccol_r;
            end
          end
        end
      end
    end
  end

  always_comb begin
    res.count = {1'b0, put_pend} + {1'b0, put_new};
    res.tok0 = put_pend ? t_pend : t_new;
    res.tok1 = t_new;
    if (!item.valid) res.count = 2'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE;
      cline_r <= 20'd1; ccol_r <= 16'd1; coff_r <= '0;
      tline_r <= 20'd1; tcol_r <= 16'd1; toff_r <= '0; tlen_r <= '0;
      acc_r <= '0; cand_r <= '1;
    end else if (item.valid) begin
      mode_r <= mode_nxt;
      cline_r <= cline_nxt; ccol_r <= ccol_nxt; coff_r <= coff_nxt;
      tline_r <= tline_nxt; tcol_r <= tcol_nxt; toff_r <= toff_nxt; tlen_r <= tlen_nxt;
      acc_r <= acc_nxt; cand_r <= cand_nxt;
    end
  end

  `include "source_text_tokenizer_assert.svh"
  `STT_ASSERT_NEXT(a_end_resets, item.valid && item.end_of_input, mode_r == M_IDLE && coff_r == '0, "end marker must reset scanner")
  `STT_ASSERT_NEXT(a_halt_holds, mode_r == M_HALT && item.valid && !item.end_of_input, mode_r == M_HALT && $stable(coff_r), "halt must freeze")
  `STT_ASSERT_IMP(a_halt_silent, mode_r == M_HALT && item.valid && !item.end_of_input, res.count == 2'd0, "halt gives no result")
endmodule

### design/stt_out.sv
// Output queue: holds up to four tokens and serializes them onto the stream
module stt_out (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  stt_pkg::res_t res,
  output logic          space,
  output logic          out_tvalid,
  input  logic          out_tready,
  output stt_pkg::tok_t out_tok,
  output logic          out_tlast
);
  import stt_pkg::*;

  tok_t q_r [4];
  logic last_r [4];
  logic [1:0] wp_r, rp_r;
  logic [2:0] cnt_r;
  logic pop;
  logic [1:0] n;

  assign n = push ? res.count : 2'd0;
  assign pop = out_tvalid && out_tready;
  assign out_tvalid = cnt_r != 3'd0;
  assign out_tok = q_r[rp_r];
  assign out_tlast = last_r[rp_r];
  assign space = (cnt_r - {2'd0, pop}) <= 3'd2;

  always_ff @(posedge clk) begin
    if (n != 2'd0) begin
      q_r[wp_r] <= res.tok0;
      last_r[wp_r] <= (n == 2'd1);
    end
    if (n == 2'd2) begin
      q_r[wp_r + 2'd1] <= res.tok1;
      last_r[wp_r + 2'd1] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      wp_r <= wp_r + n;
      rp_r <= rp_r + {1'b0, pop};
      cnt_r <= cnt_r + {1'b0, n} - {2'd0, pop};
    end
  end

  `include "source_text_tokenizer_assert.svh"
  `STT_ASSERT_IMP(a_no_overflow, 1'b1, cnt_r <= 3'd4, "queue overflow")
  `STT_ASSERT_NEXT(a_pop_moves, pop && n == 2'd0, cnt_r == $past(cnt_r) - 3'd1, "pop must drain")
  `STT_ASSERT_IMP(a_push_room, push, space, "push without room")
endmodule

### design/source_text_tokenizer.sv
// Source text tokenizer: one source byte per transaction in, tokens out.
// One byte is taken every cycle while the output queue has room for two
// tokens; each byte updates the scanner and yields zero, one or two tokens,
// which leave through a four-entry queue one per cycle unless stalled.
// Sustained rate is one byte per cycle unless the consumer stalls.
module source_text_tokenizer (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] text_byte
  input  logic         in_tlast,   // end_of_input
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [159:0] out_tdata,  // kind, line, column, offset, length, value
  output logic [1:0]   out_tuser,  // status
  output logic         out_tlast   // last_of_run
);
  import stt_pkg::*;

  item_t item;
  res_t  res;
  tok_t  tok;
  logic  space;

  assign in_tready = space;
  assign item.valid = in_tvalid && in_tready;
  assign item.text_byte = in_tdata;
  assign item.end_of_input = in_tlast;

  stt_scan u_scan (.clk(clk), .rst_n(rst_n), .item(item), .res(res));

  stt_out u_out (
    .clk(clk), .rst_n(rst_n), .push(item.valid), .res(res), .space(space),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tok(tok), .out_tlast(out_tlast)
  );

  assign out_tdata = {7'd0, tok.value, tok.length, tok.offset, tok.column, tok.line, tok.kind};
  assign out_tuser = tok.status;
endmodule

### tb/tb_source_text_tokenizer.sv
// Testbench for the source text tokenizer: directed and random token streams checked against a predictor
module tb_source_text_tokenizer;
  timeunit 1ns;
  timeprecision 1ps;
  import stt_pkg::*;

  typedef struct {
    logic [5:0]  kind;
    logic [19:0] line;
    logic [15:0] column;
    logic [31:0] offset;
    logic [15:0] length;
    logic [62:0] value;
    logic [1:0]  status;
    logic        last;
  } token_rec_t;

  class token_scoreboard;
    string kw_names[NKW] = '{"process", "coroutine", "supervisor", "spawn", "send", "recv",
      "yield", "on", "receive", "let", "mut", "fn", "return", "if", "else", "while", "true",
      "false", "int", "float", "bool", "string", "void", "restart"};
    string single_ops = "(){}[],:;.+-*/%";
    mode_t mode;
    logic [19:0] line_now, tok_line;
    logic [15:0] col_now, tok_col, tok_len;
    logic [31:0] off_now, tok_off;
    logic [63:0] accum;
    logic [NKW-1:0] kw_mask;
    token_rec_t staged[$];
    token_rec_t expected_tokens[$];
    int errors;

    function new();
      errors = 0;
      clear_state();
    endfunction

    function void clear_state();
      mode = M_IDLE;
      line_now = 1; col_now = 1; off_now = 0;
      tok_line = 1; tok_col = 1; tok_off = 0; tok_len = 0;
      accum = 0;
      kw_mask = '1;
    endfunction

    function void emit(logic [5:0] k, logic [19:0] l, logic [15:0] c, logic [31:0] o,
                       logic [15:0] n, logic [62:0] v, logic [1:0] st);
      token_rec_t r;
      if (staged.size() >= 2) return;
      r.kind = k; r.line = l; r.column = c; r.offset = o; r.length = n;
      r.value = v; r.status = st; r.last = 0;
      staged.push_back(r);
    endfunction

    function void emit_tok(logic [5:0] k, logic [62:0] v);
      emit(k, tok_line, tok_col, tok_off, tok_len, v, ST_OK);
    endfunction

    function void step_col();
      off_now++;
      if (col_now != COL_MAX) col_now++;
    endfunction

    function void step_line();
      off_now++;
      if (line_now != LINE_MAX) line_now++;
      col_now = 1;
    endfunction

    function void open_tok();
      tok_line = line_now; tok_col = col_now; tok_off = off_now; tok_len = 1;
    endfunction

    function void grow();
      if (tok_len != 16'hFFFF) tok_len++;
    endfunction

    function bit digit(logic [7:0] c);
      return c >= "0" && c <= "9";
    endfunction

    function bit alpha(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function logic [NKW-1:0] narrow(logic [NKW-1:0] m, int idx, logic [7:0] c);
      for (int k = 0; k < NKW; k++)
        if (idx >= kw_names[k].len() || kw_names[k][idx] != c) m[k] = 1'b0;
      return m;
    endfunction

    function logic [5:0] word_kind();
      for (int k = 0; k < NKW; k++)
        if (kw_mask[k] && tok_len == kw_names[k].len()) return K_KW0 + 6'(k);
      return K_IDENT;
    endfunction

    function logic [5:0] pending_op();
      case (mode)
        M_SLASH: return K_SLASH;
        M_BANG:  return K_BANG;
        M_EQ:    return K_EQ;
        M_LT:    return K_LT;
        default: return K_GT;
      endcase
    endfunction

    function void scan_fresh(logic [7:0] c);
      int op;
      mode = M_IDLE;
      if (c == " " || c == 8'h09 || c == 8'h0D) begin
        step_col();
        return;
      end
      if (c == 8'h0A) begin
        step_line();
        return;
      end
      open_tok();
      op = -1;
      for (int i = 0; i < single_ops.len(); i++) if (single_ops[i] == c) op = i;
      if (digit(c)) begin
        mode = M_INT;
        accum = 64'(c - "0");
      end else if (alpha(c)) begin
        mode = M_IDENT;
        kw_mask = narrow('1, 0, c);
      end else if (c == "\"") begin
        mode = M_STR;
        tok_off = off_now + 1;
        tok_len = 0;
      end else if (c == "/") mode = M_SLASH;
      else if (c == "!") mode = M_BANG;
      else if (c == "=") mode = M_EQ;
      else if (c == "<") mode = M_LT;
      else if (c == ">") mode = M_GT;
      else if (c == "&") mode = M_AMP;
      else if (c == "|") mode = M_BAR;
      else if (op < 0) begin
        emit(K_EOF, line_now, col_now, off_now, 1, 0, ST_UNEXP);
        mode = M_HALT;
        return;
      end else emit_tok(K_OP0 + 6'(op), 0);
      step_col();
    endfunction

    // return 1 when the byte must be scanned again from idle
    function bit scan_cont(logic [7:0] c);
      logic [63:0] d;
      case (mode)
        M_IDENT: begin
          if (alpha(c) || digit(c)) begin
            kw_mask = narrow(kw_mask, tok_len, c);
            grow(); step_col(); return 0;
          end
          emit_tok(word_kind(), 0); return 1;
        end
        M_INT: begin
          if (digit(c)) begin
            d = 64'(c - "0");
            if (accum > (64'(VAL_MAX) - d) / 10) accum = 64'(VAL_MAX);
            else accum = accum * 10 + d;
            grow(); step_col(); return 0;
          end
          if (c == ".") begin
            mode = M_FRAC; grow(); step_col(); return 0;
          end
          emit_tok(K_INT, accum[62:0]); return 1;
        end
        M_FRAC: begin
          if (digit(c)) begin
            grow(); step_col(); return 0;
          end
          emit_tok(K_FLOAT, 0); return 1;
        end
        M_STR: begin
          if (c == "\"") begin
            emit_tok(K_STRING, 0); step_col(); mode = M_IDLE; return 0;
          end
          grow();
          if (c == "\\") begin
            mode = M_ESC; step_col();
          end else if (c == 8'h0A) step_line();
          else step_col();
          return 0;
        end
        M_ESC: begin
          grow(); step_col(); mode = M_STR; return 0;
        end
        M_SLASH: begin
          if (c == "/") begin
            mode = M_COMMENT; step_col(); return 0;
          end
          emit_tok(K_SLASH, 0); return 1;
        end
        M_COMMENT: begin
          if (c == 8'h0A) return 1;
          step_col(); return 0;
        end
        M_BANG, M_EQ, M_LT, M_GT: begin
          if (c == "=") begin
            tok_len = 2;
            emit_tok(pending_op() - 6'd1, 0);
            step_col(); mode = M_IDLE; return 0;
          end
          emit_tok(pending_op(), 0); return 1;
        end
        M_AMP, M_BAR: begin
          if (c == ((mode == M_AMP) ? "&" : "|")) begin
            tok_len = 2;
            emit_tok((mode == M_AMP) ? K_ANDAND : K_OROR, 0);
            step_col(); mode = M_IDLE; return 0;
          end
          emit(K_EOF, tok_line, tok_col, tok_off, 1, 0, ST_UNEXP);
          mode = M_HALT; return 0;
        end
        default: return 0;
      endcase
    endfunction

    function void flush_pending();
      case (mode)
        M_IDENT: emit_tok(word_kind(), 0);
        M_INT:   emit_tok(K_INT, accum[62:0]);
        M_FRAC:  emit_tok(K_FLOAT, 0);
        M_SLASH, M_BANG, M_EQ, M_LT, M_GT: emit_tok(pending_op(), 0);
        M_AMP, M_BAR: emit(K_EOF, tok_line, tok_col, tok_off, 1, 0, ST_UNEXP);
        M_STR, M_ESC: emit(K_EOF, tok_line, tok_col, tok_off, tok_len, 0, ST_UNTERM);
        default: ;
      endcase
    endfunction

    function void note_byte(logic [7:0] c, logic eoi);
      staged.delete();
      if (eoi) begin
        flush_pending();
        emit(K_EOF, line_now, col_now, off_now, 0, 0, ST_OK);
        clear_state();
      end else if (mode == M_IDLE) scan_fresh(c);
      else if (mode != M_HALT) begin
        if (scan_cont(c)) scan_fresh(c);
      end
      if (staged.size() > 0) staged[staged.size()-1].last = 1;
      foreach (staged[i]) expected_tokens.push_back(staged[i]);
    endfunction

    function void report(string what, logic [63:0] got, logic [63:0] want);
      errors++;
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    endfunction

    function void check_token(logic [159:0] d, logic [1:0] u, logic l);
      token_rec_t e;
      if (expected_tokens.size() == 0) begin
        report("unexpected token kind", d[5:0], 0);
        return;
      end
      e = expected_tokens.pop_front();
      if (d[5:0] !== e.kind) report("kind", d[5:0], e.kind);
      if (d[25:6] !== e.line) report("line", d[25:6], e.line);
      if (d[41:26] !== e.column) report("column", d[41:26], e.column);
      if (d[73:42] !== e.offset) report("offset", d[73:42], e.offset);
      if (d[89:74] !== e.length) report("length", d[89:74], e.length);
      if (d[152:90] !== e.value) report("value", d[152:90], e.value);
      if (u !== e.status) report("status", u, e.status);
      if (l !== e.last) report("last", l, e.last);
    endfunction
  endclass

  logic clk, rst_n;
  logic in_tvalid, in_tready, in_tlast;
  logic [7:0] in_tdata;
  logic out_tvalid, out_tready, out_tlast;
  logic [159:0] out_tdata;
  logic [1:0] out_tuser;

  token_scoreboard sb;
  bit calm;
  bit hold_request;
  int items_sent;
  int cycle_count;
  byte text_q[$];

  source_text_tokenizer dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > 2000000) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  task automatic send_byte(logic [7:0] c, logic eoi);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 10);
    repeat (gap) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= c;
    in_tlast <= eoi;
    do @(posedge clk); while (!in_tready);
    sb.note_byte(c, eoi);
    items_sent++;
  endtask

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endtask

  task automatic send_text(bit with_end);
    foreach (text_q[i]) send_byte(text_q[i], 1'b0);
    text_q.delete();
    if (with_end) send_byte(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.expected_tokens.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic add_random_token();
    string ops[25] = '{"(", ")", "{", "}", "[", "]", ",", ":", ";", ".", "+", "-", "*",
      "/", "%", "!=", "!", "==", "=", "<=", "<", ">=", ">", "&&", "||"};
    int n;
    case ($urandom_range(0, 9))
      0: add_text(sb.kw_names[$urandom_range(0, NKW-1)]);
      1: begin
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++)
          case ($urandom_range(0, 3))
            0: text_q.push_back(8'($urandom_range("a", "z")));
            1: text_q.push_back(8'($urandom_range("A", "Z")));
            2: text_q.push_back("_");
            default: text_q.push_back(8'($urandom_range("0", "9")));
          endcase
      end
      2, 3: begin
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(18, 24) : $urandom_range(1, 5);
        for (int i = 0; i < n; i++) text_q.push_back(8'($urandom_range("0", "9")));
        if ($urandom_range(0, 3) == 0) begin
          text_q.push_back(".");
          n = $urandom_range(0, 3);
          for (int i = 0; i < n; i++) text_q.push_back(8'($urandom_range("0", "9")));
        end
      end
      4: begin
        text_q.push_back("\"");
        n = $urandom_range(0, 6);
        for (int i = 0; i < n; i++)
          case ($urandom_range(0, 4))
            0: begin
              text_q.push_back("\\");
              text_q.push_back(8'($urandom_range(1, 255)));
            end
            1: text_q.push_back(8'h0A);
            default: text_q.push_back(8'($urandom_range(" ", "~") == "\"" ?
                                         "x" : $urandom_range("#", "~")));
          endcase
        text_q.push_back("\"");
      end
      5, 6, 7: add_text(ops[$urandom_range(0, 24)]);
      8: begin
        add_text("//");
        n = $urandom_range(0, 5);
        for (int i = 0; i < n; i++) text_q.push_back(8'($urandom_range(" ", "~")));
        text_q.push_back(8'h0A);
      end
      default: text_q.push_back(8'($urandom_range(0, 255)));
    endcase
    case ($urandom_range(0, 5))
      0: text_q.push_back(8'h0A);
      1: text_q.push_back(8'h09);
      2: text_q.push_back(8'h0D);
      3: ;
      default: text_q.push_back(" ");
    endcase
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    calm = 1'b0;
    hold_request = 1'b0;
    items_sent = 0;
    sb = new();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    add_text("process coroutine supervisor spawn send recv yield on receive let mut fn ");
    add_text("return if else while true false int float bool string void restart x_9 Ab\n");
    send_text(1'b1);
    add_text("(){}[],:;.+-*/%!= ! == = <= < >= > && || a/b //c\n");
    send_text(1'b1);
    add_text("0 12.5 3. 9223372036854775807 99999999999999999999 \"a\\\"b\\");
    text_q.push_back(8'h0A);
    add_text("\" \"\" \"l1\nl2\"");
    send_text(1'b1);
    add_text("x &y");
    send_text(1'b1);
    add_text("|");
    send_text(1'b1);
    add_text("\"open\\");
    send_text(1'b1);
    add_text("a");
    text_q.push_back(8'hFF);
    add_text("b c");
    send_text(1'b1);
    add_text("ab<");
    send_text(1'b1);
    drain();

    hold_request = 1'b1;
    while (items_sent < 450) begin
      if ($urandom_range(0, 9) == 0) calm = ~calm;
      if ($urandom_range(0, 19) == 0) hold_request = 1'b1;
      if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(1, 6)) text_q.push_back(8'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(1, 8)) add_random_token();
        if ($urandom_range(0, 9) == 0) add_text("\"unterm");
      end
      send_text($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 11) == 0) drain();
    end
    send_byte(8'h00, 1'b1);
    hold_request = 1'b0;
    drain();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.expected_tokens.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    int gap;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        gap = 300;
      end else gap = calm ? 0 : $urandom_range(0, 10);
      repeat (gap) begin
        @(negedge clk);
        out_tready <= 1'b0;
      end
      @(negedge clk);
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      sb.check_token(out_tdata, out_tuser, out_tlast);
    end
  end
endmodule
